@@ design/pli_pkg.sv @@
// Shared types and constants for the piecewise linear interpolator.
package pli_pkg;

  localparam int TEMP_W = 18;
  localparam int VAL_W  = 32;
  localparam logic [TEMP_W-1:0] TEMP_MAX_RAW = 18'd160000;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_ORDER = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]               cmd;
    logic [TEMP_W-1:0]        temperature;
    logic signed [VAL_W-1:0]  point_value;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0]  result_value;
    logic [1:0]               status;
  } out_item_t;

endpackage

@@ design/pli_ram.sv @@
// Generic single-port RAM with registered read.
module pli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

@@ design/pli_div.sv @@
// Serial signed divider: one quotient bit per cycle, truncating toward zero.
module pli_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic [18:0]        den,
  output logic               done,
  output logic signed [63:0] quot
);
  logic [63:0] n_r, n_nxt;
  logic [19:0] rem_r, rem_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        neg_r, neg_nxt, run_r, run_nxt;
  logic [18:0] den_r, den_nxt;
  logic [19:0] trial;

  always_comb begin
    n_nxt = n_r; rem_nxt = rem_r; cnt_nxt = cnt_r; neg_nxt = neg_r;
    run_nxt = run_r; den_nxt = den_r;
    trial = {rem_r[18:0], n_r[63]} - {1'b0, den_r};
    if (start) begin
      neg_nxt = num[63];
      n_nxt   = num[63] ? 64'(-num) : 64'(num);
      rem_nxt = '0;
      cnt_nxt = 7'd64;
      den_nxt = den;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (!trial[19]) begin
        rem_nxt = trial;
        n_nxt   = {n_r[62:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[18:0], n_r[63]};
        n_nxt   = {n_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        run_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
      done  <= 1'b0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
      done  <= run_r && (cnt_r == 7'd1);
    end
    n_r   <= n_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
    den_r <= den_nxt;
  end

  assign quot = neg_r ? -$signed(n_r) : $signed(n_r);
endmodule

@@ design/piecewise_linear_interpolator_top.sv @@
// Top level of the piecewise linear interpolator: sequencer, point store and divider.
// Loads pass through S_LOADRD and S_LOADCHK to S_DONE; clear and unused commands go straight to S_DONE.
// A query walks the stored segments through S_WALK and S_WALKCHK, then multiplies and runs the
// 64-step serial divider; an empty store, or a temperature outside the stored points, skips the divider.
// busy is high from acceptance until the result beat; one item at a time.
// Synchronous active-low reset empties the store; the point memories are not cleared.
module piecewise_linear_interpolator_top #(
  parameter int MAX_POINTS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  pli_pkg::in_item_t  in_item,
  output logic               out_valid,
  output pli_pkg::out_item_t out_item
);
  import pli_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_LOADRD, S_LOADCHK, S_QLAST, S_QFIRST, S_WALK, S_WALKCHK,
    S_MUL, S_DIVGO, S_DIVWAIT, S_DONE
  } state_t;

  state_t state_r;
  logic [CW-1:0] count_r;
  logic [AW-1:0] idx_r;
  logic [TEMP_W-1:0] temp_r, t0_r;
  logic signed [VAL_W-1:0] val_r, k0_r;
  out_item_t res_r;
  logic signed [63:0] num_r;
  logic [18:0] den_r;

  logic mem_we;
  logic [AW-1:0] mem_addr;
  logic [TEMP_W-1:0] t_rd;
  logic signed [VAL_W-1:0] v_rd;
  logic [TEMP_W-1:0] ti16;
  logic div_start, div_done;
  logic signed [63:0] quot, sum;
  logic signed [52:0] prod;

  assign ti16 = {temp_r[TEMP_W-1:4], 4'b0};

  pli_ram #(.WIDTH(TEMP_W), .DEPTH(MAX_POINTS)) u_temps (
    .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(temp_r), .rdata(t_rd));
  pli_ram #(.WIDTH(VAL_W), .DEPTH(MAX_POINTS)) u_vals (
    .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(val_r), .rdata(v_rd));

  pli_div u_div (.clk(clk), .rst_n(rst_n), .start(div_start), .num(num_r),
    .den(den_r), .done(div_done), .quot(quot));

  assign mem_we    = (state_r == S_LOADCHK) && (res_r.status == ST_OK)
                     && !((temp_r > TEMP_MAX_RAW)
                     || (count_r != '0 && temp_r < t_rd)
                     || (count_r >= CW'(MAX_POINTS)));
  assign mem_addr  = (state_r == S_LOADCHK) ? count_r[AW-1:0] : idx_r;
  assign div_start = (state_r == S_DIVGO);
  assign sum = 64'(k0_r) + quot;
  // The value difference needs 33 bits and the temperature offset 19.
  assign prod = $signed(num_r[32:0]) * $signed({1'b0, 19'(temp_r) - 19'(t0_r)});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      out_valid <= 1'b0;
      busy      <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            busy   <= 1'b1;
            temp_r <= in_item.temperature;
            val_r  <= in_item.point_value;
            res_r  <= '{result_value: '0, status: ST_OK};
            idx_r  <= AW'(count_r - CW'(1));
            unique case (in_item.cmd)
              CMD_LOAD:  state_r <= S_LOADRD;
              CMD_QUERY: state_r <= (count_r == '0) ? S_DONE : S_QLAST;
              CMD_CLEAR: begin
                count_r <= '0;
                state_r <= S_DONE;
              end
              default:   state_r <= S_DONE;
            endcase
          end
        end
        S_LOADRD: state_r <= S_LOADCHK;
        S_LOADCHK: begin
          // Last stored temperature is on t_rd now.
          if (temp_r > TEMP_MAX_RAW) res_r.status <= ST_RANGE;
          else if (count_r != '0 && temp_r < t_rd) res_r.status <= ST_ORDER;
          else if (count_r >= CW'(MAX_POINTS)) res_r.status <= ST_FULL;
          else count_r <= count_r + CW'(1);
          state_r <= S_DONE;
        end
        S_QLAST: begin
          idx_r   <= '0;
          state_r <= S_QFIRST;
        end
        S_QFIRST: begin
          // t_rd/v_rd hold the last point.
          if (temp_r[TEMP_W-1:4] >= t_rd[TEMP_W-1:4]) begin
            res_r.result_value <= v_rd;
            state_r <= S_DONE;
          end else begin
            idx_r   <= AW'(1);
            state_r <= S_WALK;
          end
        end
        S_WALK: begin
          // t_rd/v_rd hold the first point here and each segment start later.
          if (idx_r == AW'(1) && ti16 < t_rd) begin
            res_r.result_value <= v_rd;
            state_r <= S_DONE;
          end else begin
            t0_r    <= t_rd;
            k0_r    <= v_rd;
            state_r <= S_WALKCHK;
          end
        end
        S_WALKCHK: begin
          if (ti16 >= t0_r && ti16 < t_rd) begin
            num_r   <= 64'($signed(v_rd) - $signed(k0_r));
            den_r   <= 19'(t_rd) - 19'(t0_r);
            state_r <= S_MUL;
          end else if (CW'(idx_r) + CW'(1) >= count_r) begin
            res_r.result_value <= v_rd;
            state_r <= S_DONE;
          end else begin
            idx_r   <= idx_r + AW'(1);
            state_r <= S_WALK;
          end
        end
        S_MUL: begin
          num_r   <= 64'(prod);
          state_r <= S_DIVGO;
        end
        S_DIVGO: state_r <= S_DIVWAIT;
        S_DIVWAIT: begin
          if (div_done) begin
            if (sum > 64'sd2147483647) res_r.result_value <= 32'h7FFFFFFF;
            else if (sum < -64'sd2147483648) res_r.result_value <= 32'h80000000;
            else res_r.result_value <= sum[31:0];
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          out_valid <= 1'b1;
          out_item  <= res_r;
          busy      <= 1'b0;
          state_r   <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // No new item is taken while one is in flight.
  a_busy_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> busy) else $error("busy low while working");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_POINTS)) else $error("point count overflow");
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("double result beat");
endmodule
